// ===== hdl/one_wire_bus_master_unit_assert.svh =====
// Assertion macros for the one-wire bus master
`ifndef ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH
// Check that a condition implies a consequence on the same edge.
`define OWM_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define OWM_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== hdl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the one-wire bus master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package owm_pkg;
    localparam int MAX_FORKS_DEF = 8;
    localparam int CFG_W = 10;
    localparam int NUM_CFG = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_RESET   = 3'd1;
    localparam logic [2:0] ACT_WRITE   = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_S_INIT  = 3'd4;
    localparam logic [2:0] ACT_TRIPLET = 3'd5;
    localparam logic [2:0] ACT_S_NEXT  = 3'd6;
    localparam logic [2:0] ACT_RSVD    = 3'd7;

    localparam logic [2:0] REG_RST_LOW  = 3'd0;
    localparam logic [2:0] REG_PRES     = 3'd1;
    localparam logic [2:0] REG_RST_TAIL = 3'd2;
    localparam logic [2:0] REG_SHORT    = 3'd3;
    localparam logic [2:0] REG_LONG     = 3'd4;
    localparam logic [2:0] REG_W1_HIGH  = 3'd5;
    localparam logic [2:0] REG_SAMPLE   = 3'd6;
    localparam logic [2:0] REG_RD_TAIL  = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_W_LOW, PH_W_HIGH,
        PH_R_LOW, PH_R_WAIT, PH_R_TAIL, PH_T_LOW, PH_T_WAIT, PH_T_TAIL,
        PH_TW_LOW, PH_TW_HIGH
    } t_phase;

    // one tick as seen by the back end
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_value;
        logic       bus_level;
    } t_tick;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       presence;
        logic       rom_bit;
        logic       no_device;
        logic       search_over;
    } t_result;
endpackage

// ===== hdl/owm_front.sv =====
// ----------------------------------------------------------------------------
// owm_front
// Accepts input ticks, turns unknown actions into plain ticks and queues ticks for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module owm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  owm_pkg::t_tick i_tick,
    output logic           o_valid,
    input  logic           i_ready,
    output owm_pkg::t_tick o_tick
);
    import owm_pkg::*;
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_tick           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push, pop;
    t_tick           cls;

    // action 7 means nothing: treat as a plain tick
    always_comb begin
        cls = i_tick;
        if (i_tick.action == ACT_RSVD) cls.action = ACT_NONE;
    end

    assign o_ready = (r_cnt != (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tick  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

// ===== hdl/owm_engine.sv =====
// ----------------------------------------------------------------------------
// owm_engine
// Waveform engine: runs one tick per item and returns the line drive and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module owm_engine #(
    parameter int MAX_FORKS = owm_pkg::MAX_FORKS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [9:0]       i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  owm_pkg::t_tick   i_tick,
    output logic             o_valid,
    input  logic             i_ready,
    output owm_pkg::t_result o_res
);
    import owm_pkg::*;
    localparam int LIM = (MAX_FORKS < 8) ? MAX_FORKS : 8;

    logic [CFG_W-1:0] r_cfg [NUM_CFG];
    t_phase r_ph, n_ph;
    logic [9:0] r_tc, n_tc;
    logic [2:0] r_bi, n_bi;
    logic [7:0] r_sh, n_sh, r_fm, n_fm, r_fl, n_fl, r_rd, n_rd;
    logic [1:0] r_tb, n_tb;
    logic [3:0] r_fc, n_fc;
    logic r_pres, n_pres, r_rom, n_rom, r_nd, n_nd, r_ov, n_ov;
    logic done, drive, run;
    t_result r_out;
    logic r_ov_valid;

    // a phase of zero ticks is passed in the same tick; at most eight chain
    function automatic logic [9:0] plen(t_phase p, logic wb, logic tb,
                                        logic [9:0] c0, logic [9:0] c1,
                                        logic [9:0] c2, logic [9:0] c3,
                                        logic [9:0] c4, logic [9:0] c5,
                                        logic [9:0] c6, logic [9:0] c7);
        case (p)
            PH_RST_LOW:  return c0;
            PH_RST_WAIT: return c1;
            PH_RST_TAIL: return c2;
            PH_W_LOW:    return wb ? c3 : c4;
            PH_W_HIGH:   return wb ? c5 : 10'd1;
            PH_R_LOW, PH_T_LOW:   return c3;
            PH_R_WAIT, PH_T_WAIT: return c6;
            PH_R_TAIL, PH_T_TAIL: return c7;
            PH_TW_LOW:   return tb ? c3 : c4;
            PH_TW_HIGH:  return tb ? c5 : 10'd1;
            default:     return 10'd0;
        endcase
    endfunction

    assign o_ready = !r_ov_valid || i_ready;
    assign run = i_valid && o_ready;

    always_comb begin
        logic act;
        logic [3:0] shv;
        n_ph = r_ph; n_tc = r_tc; n_bi = r_bi; n_sh = r_sh; n_fm = r_fm;
        n_fl = r_fl; n_rd = r_rd; n_tb = r_tb; n_fc = r_fc;
        n_pres = r_pres; n_rom = r_rom; n_nd = r_nd; n_ov = r_ov;
        done = 1'b0; drive = 1'b0; act = 1'b0; shv = '0;
        if (r_ph == PH_IDLE) begin
            n_tc = '0; n_bi = '0;
            case (i_tick.action)
                ACT_RESET: n_ph = PH_RST_LOW;
                ACT_WRITE: begin n_sh = i_tick.write_value; n_ph = PH_W_LOW; end
                ACT_READ:  begin n_sh = '0; n_ph = PH_R_LOW; end
                ACT_S_INIT: begin
                    n_fm = '0; n_fl = 8'hff; n_fc = '0; n_nd = 1'b0; n_ov = 1'b0;
                    done = 1'b1;
                end
                ACT_TRIPLET: begin n_tb = '0; n_ph = PH_T_LOW; end
                ACT_S_NEXT: begin
                    if (r_fl == 8'hff) n_ov = 1'b1;
                    else begin
                        shv = 4'd8 - ((r_fc > 4'd8) ? 4'd8 : r_fc);
                        n_fm = (r_fl + 8'd1) << shv;
                        n_fl = 8'hff; n_fc = '0; n_ov = 1'b0;
                    end
                    done = 1'b1;
                end
                default: ;
            endcase
        end
        for (int g = 0; g < 8; g++) begin
            if (n_ph != PH_IDLE) begin
                if (n_tc < plen(n_ph, n_sh[0], n_rom, r_cfg[0], r_cfg[1], r_cfg[2],
                                r_cfg[3], r_cfg[4], r_cfg[5], r_cfg[6], r_cfg[7])) begin
                    drive = (n_ph == PH_RST_LOW) || (n_ph == PH_W_LOW) ||
                            (n_ph == PH_R_LOW) || (n_ph == PH_T_LOW) ||
                            (n_ph == PH_TW_LOW);
                    n_tc = n_tc + 10'd1;
                    break;
                end
                case (n_ph)
                    PH_RST_LOW: n_ph = PH_RST_WAIT;
                    PH_RST_WAIT: begin n_pres = !i_tick.bus_level; n_ph = PH_RST_TAIL; end
                    PH_W_LOW: n_ph = PH_W_HIGH;
                    PH_W_HIGH: begin
                        n_sh = n_sh >> 1;
                        if (n_bi == 3'd7) n_ph = PH_IDLE;
                        else begin n_bi = n_bi + 3'd1; n_ph = PH_W_LOW; end
                    end
                    PH_R_LOW: n_ph = PH_R_WAIT;
                    PH_R_WAIT: begin
                        n_sh = {i_tick.bus_level, n_sh[7:1]}; n_ph = PH_R_TAIL;
                    end
                    PH_R_TAIL: begin
                        if (n_bi == 3'd7) begin n_rd = n_sh; n_ph = PH_IDLE; end
                        else begin n_bi = n_bi + 3'd1; n_ph = PH_R_LOW; end
                    end
                    PH_T_LOW: n_ph = PH_T_WAIT;
                    PH_T_WAIT: begin n_tb = {n_tb[0], i_tick.bus_level}; n_ph = PH_T_TAIL; end
                    PH_T_TAIL: begin
                        if (n_bi == 3'd0) begin n_bi = 3'd1; n_ph = PH_T_LOW; end
                        else if (n_tb == 2'b11) begin n_nd = 1'b1; n_ph = PH_IDLE; end
                        else begin
                            n_nd = 1'b0;
                            if (n_tb == 2'b00) begin
                                if (n_fc < 4'(LIM)) begin
                                    act = n_fm[7];
                                    n_fm = n_fm << 1;
                                    n_fl = {n_fl[6:0], act};
                                    n_fc = n_fc + 4'd1;
                                end else act = 1'b0;
                            end else act = (n_tb == 2'b10);
                            n_rom = act;
                            n_ph = PH_TW_LOW;
                        end
                    end
                    PH_TW_LOW: n_ph = PH_TW_HIGH;
                    default: n_ph = PH_IDLE;
                endcase
                n_tc = '0;
                if (n_ph == PH_IDLE) done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= 10'd480; r_cfg[1] <= 10'd37; r_cfg[2] <= 10'd147;
            r_cfg[3] <= 10'd1;   r_cfg[4] <= 10'd30; r_cfg[5] <= 10'd30;
            r_cfg[6] <= 10'd10;  r_cfg[7] <= 10'd25;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE; r_tc <= '0; r_bi <= '0; r_sh <= '0; r_fm <= '0;
            r_fl <= 8'hff; r_rd <= '0; r_tb <= '0; r_fc <= '0;
            r_pres <= 1'b0; r_rom <= 1'b0; r_nd <= 1'b0; r_ov <= 1'b0;
            r_ov_valid <= 1'b0;
        end else begin
            if (run) begin
                r_ph <= n_ph; r_tc <= n_tc; r_bi <= n_bi; r_sh <= n_sh; r_fm <= n_fm;
                r_fl <= n_fl; r_rd <= n_rd; r_tb <= n_tb; r_fc <= n_fc;
                r_pres <= n_pres; r_rom <= n_rom; r_nd <= n_nd; r_ov <= n_ov;
                r_out <= '{drive, (n_ph != PH_IDLE), done, n_rd,
                           n_pres, n_rom, n_nd, n_ov};
            end
            if (run) r_ov_valid <= 1'b1;
            else if (i_ready) r_ov_valid <= 1'b0;
        end
    end

    assign o_valid = r_ov_valid;
    assign o_res   = r_out;

    `include "one_wire_bus_master_unit_assert.svh"
    `OWM_ASSERT_IMP(a_fc_lim, i_clk, i_rst_n, 1'b1, r_fc <= 4'(LIM))
    `OWM_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_ov_valid && !i_ready, r_ov_valid)
    `OWM_ASSERT_IMP(a_busy_ph, i_clk, i_rst_n, run && done, !(n_ph != PH_IDLE))
endmodule

// ===== hdl/one_wire_bus_master_unit.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// One-wire bus master with ROM search support, one microsecond tick per item.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   tdata: action[2:0] write_value[10:3] bus_level[11]
// m_axis   out  tdata: drive_low busy_res done_res read_value presence
//                      rom_bit no_device search_over
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data
// One item per clock while neither side stalls; the engine works out each tick combinationally and registers it.
// A two-entry queue and an output register part the sides; either may stall.
// Synchronous active-low reset restores the register defaults.
`timescale 1ns / 1ps
module one_wire_bus_master_unit #(
    parameter int MAX_FORKS = owm_pkg::MAX_FORKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action, write_value, bus_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // drive_low, busy_res, done_res,
                                        // read_value, presence, rom_bit,
                                        // no_device, search_over
);
    import owm_pkg::*;
    t_tick in_t, q_t;
    t_result res;
    logic q_v, q_r;

    assign in_t.action      = s_axis_tdata[2:0];
    assign in_t.write_value = s_axis_tdata[10:3];
    assign in_t.bus_level   = s_axis_tdata[11];

    owm_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_tick(in_t), .o_valid(q_v), .i_ready(q_r), .o_tick(q_t)
    );

    owm_engine #(.MAX_FORKS(MAX_FORKS)) u_engine (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(q_v), .o_ready(q_r), .i_tick(q_t),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {1'b0, res.search_over, res.no_device, res.rom_bit,
                           res.presence, res.read_value, res.done_res,
                           res.busy_res, res.drive_low};
endmodule

// ===== dv/one_wire_bus_master_unit_tb.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit_tb
// Drives tick items into the one-wire bus master and checks every status
// item against a tick-level waveform predictor kept inside the bench.
// Covers reset/presence, byte write and read, and ROM search passes across
// several timing settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module one_wire_bus_master_unit_tb;
    import owm_pkg::*;

    localparam int WD_LIMIT = 20000;
    localparam int FORK_LIM = (MAX_FORKS_DEF < 8) ? MAX_FORKS_DEF : 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [9:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    one_wire_bus_master_unit u_dut (.*);

    // predictor state
    t_phase      ph;
    int          tcnt;
    logic [2:0]  bidx;
    logic [7:0]  shreg;
    logic [1:0]  tbits;
    logic [7:0]  fmap;
    logic [7:0]  flog;
    int          fcnt;
    logic [3:0]  st;      // presence, rom_bit, no_device, search_over
    logic [7:0]  rreg;
    int          tim [8];

    logic [11:0] tick_q [$];  // {bus_level, write_value, action}
    t_result     status_q [$];
    int          errors;
    int          gap;
    int          rhold;
    bit          pressed;
    bit          idle_on;
    int          nres;
    int          wd;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int slot_len(t_phase p);
        case (p)
            PH_RST_LOW:  return tim[REG_RST_LOW];
            PH_RST_WAIT: return tim[REG_PRES];
            PH_RST_TAIL: return tim[REG_RST_TAIL];
            PH_W_LOW:    return shreg[0] ? tim[REG_SHORT] : tim[REG_LONG];
            PH_W_HIGH:   return shreg[0] ? tim[REG_W1_HIGH] : 1;
            PH_R_LOW, PH_T_LOW:   return tim[REG_SHORT];
            PH_R_WAIT, PH_T_WAIT: return tim[REG_SAMPLE];
            PH_R_TAIL, PH_T_TAIL: return tim[REG_RD_TAIL];
            PH_TW_LOW:   return st[1] ? tim[REG_SHORT] : tim[REG_LONG];
            PH_TW_HIGH:  return st[1] ? tim[REG_W1_HIGH] : 1;
            default:     return 0;
        endcase
    endfunction

    task automatic end_slot(logic b);
        logic dir;
        case (ph)
            PH_RST_LOW:  ph = PH_RST_WAIT;
            PH_RST_WAIT: begin
                st[0] = (b == 1'b0);
                ph = PH_RST_TAIL;
            end
            PH_W_LOW:    ph = PH_W_HIGH;
            PH_W_HIGH: begin
                shreg = shreg >> 1;
                if (bidx == 3'd7) ph = PH_IDLE;
                else begin
                    bidx++;
                    ph = PH_W_LOW;
                end
            end
            PH_R_LOW:    ph = PH_R_WAIT;
            PH_R_WAIT: begin
                shreg = {b, shreg[7:1]};
                ph = PH_R_TAIL;
            end
            PH_R_TAIL: begin
                if (bidx == 3'd7) begin
                    rreg = shreg;
                    ph = PH_IDLE;
                end else begin
                    bidx++;
                    ph = PH_R_LOW;
                end
            end
            PH_T_LOW:    ph = PH_T_WAIT;
            PH_T_WAIT: begin
                tbits = {tbits[0], b};
                ph = PH_T_TAIL;
            end
            PH_T_TAIL: begin
                if (bidx == 3'd0) begin
                    bidx = 3'd1;
                    ph = PH_T_LOW;
                end else if (tbits == 2'b11) begin
                    st[2] = 1'b1;
                    ph = PH_IDLE;
                end else begin
                    st[2] = 1'b0;
                    if (tbits == 2'b00) begin
                        // fork: take the mapped direction until the log is full
                        if (fcnt < FORK_LIM) begin
                            dir = fmap[7];
                            fmap = fmap << 1;
                            flog = {flog[6:0], dir};
                            fcnt++;
                        end else dir = 1'b0;
                    end else dir = (tbits == 2'b10);
                    st[1] = dir;
                    ph = PH_TW_LOW;
                end
            end
            PH_TW_LOW:   ph = PH_TW_HIGH;
            default:     ph = PH_IDLE;
        endcase
        tcnt = 0;
    endtask

    task automatic predict_tick(logic [2:0] a, logic [7:0] wv, logic b);
        logic    done;
        logic    drv;
        logic    stop;
        int      v;
        t_result r;
        done = 1'b0;
        drv = 1'b0;
        if (ph == PH_IDLE) begin
            tcnt = 0;
            bidx = 3'd0;
            case (a)
                ACT_RESET: ph = PH_RST_LOW;
                ACT_WRITE: begin
                    shreg = wv;
                    ph = PH_W_LOW;
                end
                ACT_READ: begin
                    shreg = 8'h00;
                    ph = PH_R_LOW;
                end
                ACT_S_INIT: begin
                    fmap = 8'h00;
                    flog = 8'hff;
                    fcnt = 0;
                    st[2] = 1'b0;
                    st[3] = 1'b0;
                    done = 1'b1;
                end
                ACT_TRIPLET: begin
                    tbits = 2'b00;
                    ph = PH_T_LOW;
                end
                ACT_S_NEXT: begin
                    if (flog == 8'hff) st[3] = 1'b1;
                    else begin
                        v = ((int'(flog) + 1) & 255) << (8 - (fcnt > 8 ? 8 : fcnt));
                        fmap = v[7:0];
                        flog = 8'hff;
                        fcnt = 0;
                        st[3] = 1'b0;
                    end
                    done = 1'b1;
                end
                default: ;
            endcase
        end
        stop = 1'b0;
        for (int g = 0; g < 64 && !stop; g++) begin
            if (ph == PH_IDLE) stop = 1'b1;
            else if (tcnt < slot_len(ph)) begin
                drv = (ph == PH_RST_LOW || ph == PH_W_LOW || ph == PH_R_LOW ||
                       ph == PH_T_LOW || ph == PH_TW_LOW);
                tcnt++;
                stop = 1'b1;
            end else begin
                end_slot(b);
                if (ph == PH_IDLE) done = 1'b1;
            end
        end
        r.drive_low   = drv;
        r.busy_res    = (ph != PH_IDLE);
        r.done_res    = done;
        r.read_value  = rreg;
        r.presence    = st[0];
        r.rom_bit     = st[1];
        r.no_device   = st[2];
        r.search_over = st[3];
        status_q.push_back(r);
    endtask

    task automatic report(string what, int got, int want);
        errors++;
        $display("ERROR: %s got %0d expected %0d (item %0d)", what, got, want, nres);
    endtask

    task automatic check_status(logic [15:0] d);
        t_result e;
        if (status_q.size() == 0) begin
            report("unexpected item", d, 0);
            return;
        end
        e = status_q.pop_front();
        if (d[0] !== e.drive_low)     report("drive_low", d[0], e.drive_low);
        if (d[1] !== e.busy_res)      report("busy_res", d[1], e.busy_res);
        if (d[2] !== e.done_res)      report("done_res", d[2], e.done_res);
        if (d[10:3] !== e.read_value) report("read_value", d[10:3], e.read_value);
        if (d[11] !== e.presence)     report("presence", d[11], e.presence);
        if (d[12] !== e.rom_bit)      report("rom_bit", d[12], e.rom_bit);
        if (d[13] !== e.no_device)    report("no_device", d[13], e.no_device);
        if (d[14] !== e.search_over)  report("search_over", d[14], e.search_over);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_tick(s_axis_tdata[2:0], s_axis_tdata[10:3], s_axis_tdata[11]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    gap <= gap - 1;
                end else if (tick_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'b0, tick_q.pop_front()};
                    gap <= idle_on ? rand_gap() : 0;
                end else s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rhold <= 0;
            pressed <= 1'b0;
            nres <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_status(m_axis_tdata);
                nres <= nres + 1;
            end
            if (!pressed && nres >= 250 && tick_q.size() > 8) begin
                // hold off long enough to back up the input side
                m_axis_tready <= 1'b0;
                rhold <= 400;
                pressed <= 1'b1;
            end else if (rhold > 0) begin
                m_axis_tready <= 1'b0;
                rhold <= rhold - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready && idle_on) rhold <= rand_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) wd <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            wd <= 0;
        else begin
            wd <= wd + 1;
            if (wd >= WD_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic push_tick(logic [2:0] a, logic [7:0] wv, logic b);
        tick_q.push_back({b, wv, a});
    endtask

    // wait for everything to drain, then pad with plain ticks until idle
    task automatic drain(int fill_bus);
        bit idle;
        idle = 1'b0;
        while (!idle) begin
            while (tick_q.size() > 0 || s_axis_tvalid || status_q.size() > 0)
                @(posedge i_clk);
            if (ph == PH_IDLE) idle = 1'b1;
            else
                repeat (8)
                    push_tick(ACT_NONE, 8'($urandom),
                              fill_bus > 1 ? 1'($urandom) : 1'(fill_bus));
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_timing(int t0, int t1, int t2, int t3, int t4, int t5,
                              int t6, int t7);
        int vals [8];
        vals = '{t0, t1, t2, t3, t4, t5, t6, t7};
        for (int k = 0; k < NUM_CFG; k++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(k);
            i_cfg_data <= 10'(vals[k]);
            tim[k] = vals[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic cmd(logic [2:0] a, logic [7:0] wv, int fill_bus);
        push_tick(a, wv, fill_bus > 1 ? 1'($urandom) : 1'(fill_bus));
        drain(fill_bus);
    endtask

    // bus0_pct biases the line low so that forks and presence show up
    task automatic random_ticks(int n, int bus0_pct, bit search_only);
        logic [2:0] a;
        int p;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 80) a = ACT_NONE;
            else if (search_only)
                a = (p < 94) ? ACT_TRIPLET : (p < 98) ? ACT_S_NEXT : ACT_S_INIT;
            else if (p < 82) a = ACT_RSVD;
            else a = 3'($urandom_range(1, 6));
            push_tick(a, 8'($urandom), $urandom_range(0, 99) >= bus0_pct);
        end
        drain(2);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        idle_on = 1'b1;
        tim = '{480, 37, 147, 1, 30, 30, 10, 25};
        ph = PH_IDLE;
        tcnt = 0; bidx = 0; shreg = 0; tbits = 0;
        fmap = 8'h00; flog = 8'hff; fcnt = 0; st = 4'h0; rreg = 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        set_timing(3, 2, 2, 1, 4, 2, 1, 1);
        // directed: presence and no presence, byte extremes, search corners
        cmd(ACT_RESET, 8'h00, 0);
        cmd(ACT_RESET, 8'h00, 1);
        cmd(ACT_WRITE, 8'h00, 2);
        cmd(ACT_WRITE, 8'hff, 2);
        cmd(ACT_WRITE, 8'ha5, 2);
        cmd(ACT_READ, 8'h00, 1);
        cmd(ACT_READ, 8'h00, 0);
        cmd(ACT_S_NEXT, 8'h00, 2);     // log all ones: search over
        cmd(ACT_S_INIT, 8'h00, 2);
        cmd(ACT_TRIPLET, 8'h00, 1);    // both bits high: no device
        for (int k = 0; k < 9; k++)    // forks past the log limit
            cmd(ACT_TRIPLET, 8'h00, 0);
        cmd(ACT_S_NEXT, 8'h00, 2);
        cmd(ACT_RSVD, 8'h00, 2);       // unknown action

        random_ticks(50, 50, 1'b0);
        set_timing(1, 1, 0, 1, 1, 0, 0, 0);
        random_ticks(50, 70, 1'b1);
        idle_on = 1'b0;
        set_timing($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 6),
                   $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 6),
                   $urandom_range(0, 6), $urandom_range(0, 6));
        random_ticks(50, 60, 1'b0);
        idle_on = 1'b1;
        set_timing($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 4),
                   $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 4),
                   $urandom_range(0, 4), $urandom_range(0, 4));
        random_ticks(50, 75, 1'b1);

        set_timing(10, 5, 4, 2, 6, 3, 2, 2);
        cmd(ACT_RESET, 8'h00, 0);
        cmd(ACT_WRITE, 8'h5a, 2);
        cmd(ACT_TRIPLET, 8'h00, 2);
        cmd(ACT_RESET, 8'h00, 2);
        cmd(ACT_READ, 8'h00, 2);
        random_ticks(30, 50, 1'b0);

        repeat (20) @(posedge i_clk);
        if (errors == 0 && status_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
